// ----- rtl/wsfc_pkg.sv -----
// Shared types, field widths, command codes and the control store of the word store.
// No dependencies; every other file in rtl/ takes its names from here.
package wsfc_pkg;

  // Field widths on the two channels
  localparam int CMD_W   = 3;
  localparam int INDEX_W = 17;
  localparam int VALUE_W = 32;
  localparam int RDATA_W = 18;
  localparam int FREE_W  = 17;

  // Stored word width, internal index width (room for source running past target)
  localparam int WORD_W = 17;
  localparam int IDX_W  = 19;

  localparam int DEPTH_DEFAULT = 256;

  // Largest value kept after digit dropping, and the reciprocal of ten (shift 35)
  localparam logic [VALUE_W-1:0] VAL_MAX   = 32'd99999;
  localparam logic [63:0]        RECIP_TEN = 64'h0000_0000_CCCC_CCCD;
  localparam int                 RECIP_SH  = 35;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COPY      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BLOCK     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd6;

  // Micro-operations on the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_DISPATCH,   // wait for a beat, load it, jump to the command's routine
    OP_DIV10,      // drop one low decimal digit while the value is too large
    OP_VAL_RDATA,  // value <= read data
    OP_VAL_ZERO,   // value <= 0
    OP_PUT,        // store value at dest, adjust free count from old word
    OP_TAKE_RD,    // result word <= read data
    OP_RD_NEG,     // result word <= -1
    OP_INC,        // advance dest and source
    OP_SWEEP,      // store zero at dest, advance dest
    OP_CLR_D,      // dest <= 0
    OP_FREE_ALL,   // free count <= depth
    OP_EMIT        // load the result register
  } uop_t;

  // Memory read address select
  typedef enum logic [1:0] {
    RS_NONE,
    RS_D,
    RS_S
  } rsel_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_BAD_D,       // dest out of range
    C_BAD_COPY,    // store empty, or dest or source out of range
    C_BAD_RANGE,   // block copy range rejected
    C_BIG,         // value above the kept maximum
    C_FREE_FULL,   // store empty
    C_FREE_ZERO,   // store full
    C_RDATA_NZ,    // read word occupied
    C_D_LT_LAST,   // dest below last dest
    C_D_LT_TOP     // dest below last entry
  } cond_t;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    uop_t  op;
    rsel_t rsel;
    logic  ok_set;
    logic  wait_out;
    cond_t cond;
    step_t jump;
  } ucw_t;

  // Step addresses of the control store
  localparam step_t ST_IDLE     = 5'd0;
  localparam step_t ST_RD0      = 5'd1;
  localparam step_t ST_RD1      = 5'd2;
  localparam step_t ST_RDBAD    = 5'd3;
  localparam step_t ST_WR0      = 5'd4;
  localparam step_t ST_WR1      = 5'd5;
  localparam step_t ST_WR2      = 5'd6;
  localparam step_t ST_IN0      = 5'd7;
  localparam step_t ST_IN1      = 5'd8;
  localparam step_t ST_IN2      = 5'd9;
  localparam step_t ST_IN3      = 5'd10;
  localparam step_t ST_INW      = 5'd11;
  localparam step_t ST_INNX     = 5'd12;
  localparam step_t ST_CP0      = 5'd13;
  localparam step_t ST_CP1      = 5'd14;
  localparam step_t ST_CP2      = 5'd15;
  localparam step_t ST_BC0      = 5'd16;
  localparam step_t ST_BC1      = 5'd17;
  localparam step_t ST_BC2      = 5'd18;
  localparam step_t ST_BC3      = 5'd19;
  localparam step_t ST_BC4      = 5'd20;
  localparam step_t ST_BC5      = 5'd21;
  localparam step_t ST_DONE     = 5'd22;
  localparam step_t ST_CE0      = 5'd23;
  localparam step_t ST_CE1      = 5'd24;
  localparam step_t ST_CA0      = 5'd25;
  localparam step_t ST_CA1      = 5'd26;
  localparam step_t ST_CA2      = 5'd27;
  localparam step_t ST_INIT     = 5'd28;
  localparam step_t ST_INIT_END = 5'd29;

  function automatic ucw_t mk(uop_t op, rsel_t rsel, logic ok_set, logic wait_out,
                              cond_t cond, step_t jump);
    ucw_t w;
    w.op       = op;
    w.rsel     = rsel;
    w.ok_set   = ok_set;
    w.wait_out = wait_out;
    w.cond     = cond;
    w.jump     = jump;
    return w;
  endfunction

  // Control store: one word per step
  function automatic ucw_t ucode(step_t st);
    ucw_t w;
    w = mk(OP_NOP, RS_NONE, 1'b0, 1'b0, C_ALWAYS, ST_IDLE);
    case (st)
      ST_IDLE:     w = mk(OP_DISPATCH,  RS_NONE, 1'b0, 1'b0, C_NEVER,     ST_IDLE);
      // read
      ST_RD0:      w = mk(OP_NOP,       RS_D,    1'b0, 1'b0, C_BAD_D,     ST_RDBAD);
      ST_RD1:      w = mk(OP_TAKE_RD,   RS_NONE, 1'b1, 1'b0, C_ALWAYS,    ST_DONE);
      ST_RDBAD:    w = mk(OP_RD_NEG,    RS_NONE, 1'b0, 1'b0, C_ALWAYS,    ST_DONE);
      // write
      ST_WR0:      w = mk(OP_NOP,       RS_NONE, 1'b0, 1'b0, C_BAD_D,     ST_DONE);
      ST_WR1:      w = mk(OP_DIV10,     RS_D,    1'b0, 1'b0, C_BIG,       ST_WR1);
      ST_WR2:      w = mk(OP_PUT,       RS_NONE, 1'b1, 1'b0, C_ALWAYS,    ST_DONE);
      // insert at the lowest empty entry
      ST_IN0:      w = mk(OP_CLR_D,     RS_NONE, 1'b0, 1'b0, C_FREE_ZERO, ST_DONE);
      ST_IN1:      w = mk(OP_DIV10,     RS_NONE, 1'b0, 1'b0, C_BIG,       ST_IN1);
      ST_IN2:      w = mk(OP_NOP,       RS_D,    1'b0, 1'b0, C_NEVER,     ST_IDLE);
      ST_IN3:      w = mk(OP_NOP,       RS_NONE, 1'b0, 1'b0, C_RDATA_NZ,  ST_INNX);
      ST_INW:      w = mk(OP_PUT,       RS_NONE, 1'b1, 1'b0, C_ALWAYS,    ST_DONE);
      ST_INNX:     w = mk(OP_INC,       RS_NONE, 1'b0, 1'b0, C_ALWAYS,    ST_IN2);
      // copy one word
      ST_CP0:      w = mk(OP_NOP,       RS_S,    1'b0, 1'b0, C_BAD_COPY,  ST_DONE);
      ST_CP1:      w = mk(OP_VAL_RDATA, RS_D,    1'b0, 1'b0, C_NEVER,     ST_IDLE);
      ST_CP2:      w = mk(OP_PUT,       RS_NONE, 1'b1, 1'b0, C_ALWAYS,    ST_DONE);
      // block copy, forward
      ST_BC0:      w = mk(OP_NOP,       RS_NONE, 1'b0, 1'b0, C_FREE_FULL, ST_DONE);
      ST_BC1:      w = mk(OP_NOP,       RS_NONE, 1'b1, 1'b0, C_BAD_RANGE, ST_DONE);
      ST_BC2:      w = mk(OP_NOP,       RS_S,    1'b0, 1'b0, C_BAD_COPY,  ST_BC5);
      ST_BC3:      w = mk(OP_VAL_RDATA, RS_D,    1'b0, 1'b0, C_NEVER,     ST_IDLE);
      ST_BC4:      w = mk(OP_PUT,       RS_NONE, 1'b0, 1'b0, C_NEVER,     ST_IDLE);
      ST_BC5:      w = mk(OP_INC,       RS_NONE, 1'b0, 1'b0, C_D_LT_LAST, ST_BC2);
      // hand the result over
      ST_DONE:     w = mk(OP_EMIT,      RS_NONE, 1'b0, 1'b1, C_ALWAYS,    ST_IDLE);
      // clear one entry
      ST_CE0:      w = mk(OP_VAL_ZERO,  RS_D,    1'b0, 1'b0, C_BAD_D,     ST_DONE);
      ST_CE1:      w = mk(OP_PUT,       RS_NONE, 1'b1, 1'b0, C_ALWAYS,    ST_DONE);
      // clear all
      ST_CA0:      w = mk(OP_CLR_D,     RS_NONE, 1'b0, 1'b0, C_FREE_FULL, ST_DONE);
      ST_CA1:      w = mk(OP_SWEEP,     RS_NONE, 1'b0, 1'b0, C_D_LT_TOP,  ST_CA1);
      ST_CA2:      w = mk(OP_FREE_ALL,  RS_NONE, 1'b1, 1'b0, C_ALWAYS,    ST_DONE);
      // clearing pass after reset
      ST_INIT:     w = mk(OP_SWEEP,     RS_NONE, 1'b0, 1'b0, C_D_LT_TOP,  ST_INIT);
      ST_INIT_END: w = mk(OP_NOP,       RS_NONE, 1'b0, 1'b0, C_ALWAYS,    ST_IDLE);
      default:     w = mk(OP_NOP,       RS_NONE, 1'b0, 1'b0, C_ALWAYS,    ST_IDLE);
    endcase
    return w;
  endfunction

  // Dispatch table: first step of each command's routine
  function automatic step_t entry(logic [CMD_W-1:0] cmd);
    step_t st;
    st = ST_DONE;
    case (cmd)
      CMD_READ:      st = ST_RD0;
      CMD_WRITE:     st = ST_WR0;
      CMD_INSERT:    st = ST_IN0;
      CMD_COPY:      st = ST_CP0;
      CMD_BLOCK:     st = ST_BC0;
      CMD_CLEAR:     st = ST_CE0;
      CMD_CLEAR_ALL: st = ST_CA0;
      default:       st = ST_DONE;
    endcase
    return st;
  endfunction

endpackage

// ----- rtl/wsfc_if.sv -----
// Command and response channels of the word store: valid/ready plus payload.
// Depends on wsfc_pkg for field widths.
interface wsfc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [wsfc_pkg::CMD_W-1:0]           cmd;
  logic signed [wsfc_pkg::INDEX_W-1:0]  target;
  logic signed [wsfc_pkg::INDEX_W-1:0]  source_index;
  logic signed [wsfc_pkg::INDEX_W-1:0]  target_last;
  logic signed [wsfc_pkg::VALUE_W-1:0]  write_value;

  modport source (output valid, cmd, target, source_index, target_last, write_value,
                  input ready);
  modport sink   (input valid, cmd, target, source_index, target_last, write_value,
                  output ready);
endinterface

interface wsfc_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 ok;
  logic signed [wsfc_pkg::RDATA_W-1:0]  read_data;
  logic [wsfc_pkg::FREE_W-1:0]          free_count;

  modport source (output valid, ok, read_data, free_count, input ready);
  modport sink   (input valid, ok, read_data, free_count, output ready);
endinterface

// ----- rtl/word_store_with_free_count_unit.sv -----
// Word store with a running count of empty entries, run by a microcoded sequencer.
// Depends on wsfc_pkg (types, control store) and wsfc_if (channel interfaces).

// A store of DEPTH words where a zero word marks an empty entry; free_count in every
// result is the number of empty entries after the command. All work goes through one
// memory with a single write and a single registered read port. A write or insert
// first drops low decimal digits, at most 5, while the value is above the kept
// maximum; an insert then scans up past occupied entries to the first empty one,
// and a block copy skips an entry whose destination or source is out of range. A
// write, copy or clear with a bad index, an insert into a full store, a block copy or
// clear all on an empty store and a rejected block copy range go straight to the
// result step. The next command is taken in the cycle after the result is loaded;
// while an earlier result still waits in the output register the result step holds.
// After reset a clearing pass zeroes the memory while no command is accepted.
module word_store_with_free_count_unit #(
  parameter int DEPTH = wsfc_pkg::DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  wsfc_req_if.sink    req,
  wsfc_rsp_if.source  rsp
);
  import wsfc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic signed [IDX_W-1:0] DEPTH_S = IDX_W'(DEPTH);
  localparam logic signed [IDX_W-1:0] TOP_S   = IDX_W'(DEPTH - 1);
  localparam logic [FW-1:0]           FREE_MAX = FW'(DEPTH);

  // Sequencer
  step_t pc;
  step_t pc_next;
  ucw_t  uw;

  // Datapath registers
  logic signed [IDX_W-1:0]   d;
  logic signed [IDX_W-1:0]   s;
  logic signed [IDX_W-1:0]   last;
  logic [VALUE_W-1:0]        val;
  logic                      ok;
  logic signed [RDATA_W-1:0] rd;
  logic [FW-1:0]             free;
  logic [WORD_W-1:0]         rdata;

  // Memory
  logic [WORD_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic              rd_en;
  logic [AW-1:0]     raddr;

  logic               req_fire;
  logic               stall;
  logic               cond_met;
  logic               d_ok;
  logic               s_ok;
  logic [63:0]        prod;
  logic [VALUE_W-1:0] wv;
  logic [VALUE_W-1:0] mag;
  logic               old_nz;
  logic               new_nz;

  assign uw       = ucode(pc);
  assign req.ready = (pc == ST_IDLE);
  assign req_fire = req.valid && req.ready;
  assign stall    = uw.wait_out && rsp.valid && !rsp.ready;

  // Range checks and magnitude of the incoming value
  assign d_ok = (d >= 0) && (d < DEPTH_S);
  assign s_ok = (s >= 0) && (s < DEPTH_S);
  assign wv   = req.write_value;
  assign mag  = wv[VALUE_W-1] ? (~wv + 32'd1) : wv;
  assign prod = {32'b0, val} * RECIP_TEN;

  // Evaluate the jump condition of the current step
  always_comb begin
    case (uw.cond)
      C_NEVER:     cond_met = 1'b0;
      C_ALWAYS:    cond_met = 1'b1;
      C_BAD_D:     cond_met = !d_ok;
      C_BAD_COPY:  cond_met = (free == FREE_MAX) || !d_ok || !s_ok;
      C_BAD_RANGE: cond_met = !((last >= d) && (last < DEPTH_S));
      C_BIG:       cond_met = val > VAL_MAX;
      C_FREE_FULL: cond_met = free == FREE_MAX;
      C_FREE_ZERO: cond_met = free == '0;
      C_RDATA_NZ:  cond_met = rdata != '0;
      C_D_LT_LAST: cond_met = d < last;
      C_D_LT_TOP:  cond_met = d < TOP_S;
      default:     cond_met = 1'b0;
    endcase
  end

  // Next step: dispatch on a beat, hold on a busy output, else jump or advance
  always_comb begin
    if (uw.op == OP_DISPATCH) begin
      pc_next = req_fire ? entry(req.cmd) : pc;
    end else if (stall) begin
      pc_next = pc;
    end else if (cond_met) begin
      pc_next = uw.jump;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_INIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Memory ports
  assign mem_we    = (uw.op == OP_PUT) || (uw.op == OP_SWEEP);
  assign mem_wdata = (uw.op == OP_PUT) ? val[WORD_W-1:0] : '0;
  assign rd_en     = uw.rsel != RS_NONE;
  assign raddr     = (uw.rsel == RS_S) ? s[AW-1:0] : d[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[d[AW-1:0]] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Free count follows every value store; a sweep of zeros leaves it alone, reset and clear all set it to the depth
  assign old_nz = rdata != '0;
  assign new_nz = val[WORD_W-1:0] != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      free <= FREE_MAX;
    end else if (uw.op == OP_FREE_ALL) begin
      free <= FREE_MAX;
    end else if (uw.op == OP_PUT) begin
      if (old_nz && !new_nz) begin
        free <= free + FW'(1);
      end else if (!old_nz && new_nz) begin
        free <= free - FW'(1);
      end
    end
  end

  // Dest index: cleared at reset for the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      d <= '0;
    end else if (req_fire) begin
      d <= IDX_W'(req.target);
    end else begin
      case (uw.op)
        OP_CLR_D:           d <= '0;
        OP_INC, OP_SWEEP:   d <= d + IDX_W'(1);
        default:            d <= d;
      endcase
    end
  end

  // Operand, value and result word registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s    <= IDX_W'(req.source_index);
      last <= IDX_W'(req.target_last);
      val  <= mag;
      ok   <= 1'b0;
      rd   <= '0;
    end else begin
      if (uw.op == OP_INC) begin
        s <= s + IDX_W'(1);
      end
      case (uw.op)
        OP_DIV10:     val <= (val > VAL_MAX) ? VALUE_W'(prod[63:RECIP_SH]) : val;
        OP_VAL_RDATA: val <= VALUE_W'(rdata);
        OP_VAL_ZERO:  val <= '0;
        default:      val <= val;
      endcase
      case (uw.op)
        OP_TAKE_RD: rd <= RDATA_W'(rdata);
        OP_RD_NEG:  rd <= '1;
        default:    rd <= rd;
      endcase
      if (uw.ok_set) begin
        ok <= 1'b1;
      end
    end
  end

  // Result register: load on emit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (uw.op == OP_EMIT && !stall) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT && !stall) begin
      rsp.ok         <= ok;
      rsp.read_data  <= rd;
      rsp.free_count <= FREE_W'(free);
    end
  end

`ifndef SYNTH
  // Free count never exceeds the depth
  a_free_bound: assert property (@(posedge clk) disable iff (rst) free <= FREE_MAX)
    else $error("free count above depth");

  // Every store goes to an entry inside the memory
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (d >= 0) && (d < DEPTH_S))
    else $error("store to an index outside the memory");

  // An accepted command always leaves the dispatch step
  a_dispatch_leaves: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req.ready)
    else $error("command accepted without starting its routine");

  // A result reporting -1 never reports success
  a_neg_fails: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.read_data == '1) |-> !rsp.ok)
    else $error("read of -1 reported as success");
`endif

endmodule
